### hw/rtl/ofp_pkg.sv
`timescale 1ns / 1ps

package ofp_pkg;

  // Frame layout
  localparam logic [7:0] HEADER_BYTE = 8'hAA;
  localparam logic [7:0] SOURCE_BYTE = 8'h22;
  localparam logic [7:0] FUNC_FLOW   = 8'h51;
  localparam logic [7:0] FUNC_HEIGHT = 8'h52;
  localparam logic [7:0] MODE_RAW    = 8'h00;
  localparam logic [7:0] MODE_FUSED  = 8'h01;

  localparam int FRAME_BYTES = 64;
  // Longest payload that fits a frame of FRAME_BYTES bytes
  localparam logic [7:0] MAX_LEN = 8'(FRAME_BYTES - 6);
  localparam int LEN_W = $clog2(FRAME_BYTES - 5);

  // Shortest payload for each decoded frame kind
  localparam logic [LEN_W-1:0] MIN_LEN_RAW_FLOW   = LEN_W'(5);
  localparam logic [LEN_W-1:0] MIN_LEN_FUSED_FLOW = LEN_W'(15);
  localparam logic [LEN_W-1:0] MIN_LEN_HEIGHT     = LEN_W'(3);
  // Payload bytes kept for decoding (payload byte 0 is the mode byte)
  localparam int PL_KEEP = 14;

  // Configuration
  localparam logic REG_LINK_TIMEOUT    = 1'b0;
  localparam logic REG_SILENCE_CEILING = 1'b1;
  localparam logic [15:0] LINK_TIMEOUT_RESET    = 16'd1000;
  localparam logic [15:0] SILENCE_CEILING_RESET = 16'd10000;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = QUEUE_PTR_W + 1;

  typedef enum logic [3:0] {
    KIND_BUSY         = 4'd0,
    KIND_RAW_FLOW     = 4'd1,
    KIND_FUSED_FLOW   = 4'd2,
    KIND_RAW_HEIGHT   = 4'd3,
    KIND_FUSED_HEIGHT = 4'd4,
    KIND_CSUM_BAD     = 4'd5,
    KIND_IGNORED      = 4'd6,
    KIND_LEN_ERR      = 4'd7,
    KIND_HEALTH       = 4'd8
  } kind_t;

  typedef struct packed {
    logic       is_tick;
    logic [7:0] value;
  } item_t;

  typedef struct packed {
    logic [15:0] link_timeout_ms;
    logic [15:0] silence_ceiling_ms;
  } cfg_t;

  typedef struct packed {
    kind_t              result_kind;
    logic        [7:0]  quality;
    logic signed [7:0]  dx_raw;
    logic signed [7:0]  dy_raw;
    logic        [7:0]  light_level;
    logic signed [15:0] dx_fused;
    logic signed [15:0] dy_fused;
    logic signed [15:0] dx_corrected;
    logic signed [15:0] dy_corrected;
    logic        [15:0] altitude;
    logic               link_ok;
  } result_t;

endpackage

### hw/rtl/ofp_front.sv
`timescale 1ns / 1ps

module ofp_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_type,
  input  logic [15:0]         in_data,
  output logic                q_valid,
  input  logic                q_ready,
  output ofp_pkg::item_t      q_item
);

  ofp_pkg::item_t                   queue [ofp_pkg::QUEUE_DEPTH];
  logic [ofp_pkg::QUEUE_PTR_W-1:0]  wr_ptr;
  logic [ofp_pkg::QUEUE_PTR_W-1:0]  rd_ptr;
  logic [ofp_pkg::QUEUE_CNT_W-1:0]  count;
  ofp_pkg::item_t                   item_in;
  logic                             push;
  logic                             pop;

  // Classify: keep only the byte that the item kind uses
  always_comb begin
    item_in.is_tick = in_type;
    item_in.value   = in_type ? in_data[15:8] : in_data[7:0];
  end

  assign in_ready = (count != ofp_pkg::QUEUE_CNT_W'(ofp_pkg::QUEUE_DEPTH));
  assign q_valid  = (count != '0);
  assign q_item   = queue[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### hw/rtl/ofp_back.sv
`timescale 1ns / 1ps

module ofp_back (
  input  logic               clk,
  input  logic               rst,
  input  ofp_pkg::cfg_t      cfg,
  input  logic               q_valid,
  output logic               q_ready,
  input  ofp_pkg::item_t     q_item,
  output logic               out_valid,
  input  logic               out_ready,
  output ofp_pkg::result_t   out_result
);

  typedef enum logic [6:0] {
    PH_HUNT    = 7'b0000001,
    PH_SRC     = 7'b0000010,
    PH_DST     = 7'b0000100,
    PH_FUNC    = 7'b0001000,
    PH_LEN     = 7'b0010000,
    PH_PAYLOAD = 7'b0100000,
    PH_SUM     = 7'b1000000
  } phase_t;

  phase_t                         phase;
  phase_t                         phase_next;
  logic [ofp_pkg::LEN_W-1:0]      left;
  logic [ofp_pkg::LEN_W-1:0]      left_next;
  logic [ofp_pkg::LEN_W-1:0]      pcount;
  logic [ofp_pkg::LEN_W-1:0]      pcount_next;
  logic [7:0]                     rsum;
  logic [7:0]                     rsum_next;
  logic [1:0]                     seen;
  logic [1:0]                     seen_next;
  logic [15:0]                    sil0;
  logic [15:0]                    sil0_next;
  logic [15:0]                    sil1;
  logic [15:0]                    sil1_next;
  logic                           link_state;
  logic                           link_next;

  // Kept frame bytes: function code, mode byte, payload bytes 1..14
  logic [7:0]                     func_b;
  logic [7:0]                     mode_b;
  logic [7:0]                     pl [1:ofp_pkg::PL_KEEP];

  logic                           pop;
  logic                           store_func;
  logic                           store_pl;
  logic [7:0]                     b;
  ofp_pkg::result_t               res;

  function automatic logic [15:0] age(input logic [15:0] cnt, input logic seen_i,
                                      input logic [7:0] ms, input logic [15:0] ceil);
    logic [16:0] s;
    s = {1'b0, cnt} + {9'b0, ms};
    if (seen_i) begin
      age = '0;
    end else if (cnt < ceil) begin
      age = s[16] ? 16'hFFFF : s[15:0];
    end else begin
      age = cnt;
    end
  endfunction

  assign q_ready = !out_valid || out_ready;
  assign pop     = q_valid && q_ready;
  assign b       = q_item.value;

  always_comb begin
    phase_next  = phase;
    left_next   = left;
    pcount_next = pcount;
    rsum_next   = rsum;
    seen_next   = seen;
    sil0_next   = sil0;
    sil1_next   = sil1;
    link_next   = link_state;
    store_func  = 1'b0;
    store_pl    = 1'b0;
    res         = '0;
    res.result_kind = ofp_pkg::KIND_BUSY;

    if (q_item.is_tick) begin
      sil0_next = age(sil0, seen[0], b, cfg.silence_ceiling_ms);
      sil1_next = age(sil1, seen[1], b, cfg.silence_ceiling_ms);
      seen_next = '0;
      link_next = !((sil0_next > cfg.link_timeout_ms) || (sil1_next > cfg.link_timeout_ms));
      res.result_kind = ofp_pkg::KIND_HEALTH;
    end else begin
      case (phase)
        PH_HUNT: begin
          if (b == ofp_pkg::HEADER_BYTE) begin
            rsum_next  = b;
            phase_next = PH_SRC;
          end
        end
        PH_SRC: begin
          if (b != ofp_pkg::SOURCE_BYTE) begin
            phase_next = PH_HUNT;
          end else begin
            rsum_next  = rsum + b;
            phase_next = PH_DST;
          end
        end
        PH_DST: begin
          rsum_next  = rsum + b;
          phase_next = PH_FUNC;
        end
        PH_FUNC: begin
          rsum_next  = rsum + b;
          store_func = 1'b1;
          phase_next = PH_LEN;
        end
        PH_LEN: begin
          rsum_next   = rsum + b;
          pcount_next = '0;
          left_next   = b[ofp_pkg::LEN_W-1:0];
          if (b > ofp_pkg::MAX_LEN) begin
            res.result_kind = ofp_pkg::KIND_LEN_ERR;
            phase_next      = PH_HUNT;
          end else begin
            phase_next = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          // zero length: drop one byte and hunt again
          if (left == '0) begin
            phase_next = PH_HUNT;
          end else begin
            store_pl    = 1'b1;
            rsum_next   = rsum + b;
            pcount_next = pcount + 1'b1;
            left_next   = left - 1'b1;
            if (left == ofp_pkg::LEN_W'(1)) begin
              phase_next = PH_SUM;
            end
          end
        end
        PH_SUM: begin
          phase_next = PH_HUNT;
          if (b != rsum) begin
            res.result_kind = ofp_pkg::KIND_CSUM_BAD;
          end else if (func_b == ofp_pkg::FUNC_FLOW) begin
            if (mode_b == ofp_pkg::MODE_RAW) begin
              if (pcount < ofp_pkg::MIN_LEN_RAW_FLOW) begin
                res.result_kind = ofp_pkg::KIND_LEN_ERR;
              end else begin
                res.result_kind = ofp_pkg::KIND_RAW_FLOW;
                res.quality     = pl[1];
                res.dx_raw      = pl[2];
                res.dy_raw      = pl[3];
                res.light_level = pl[4];
              end
            end else if (mode_b == ofp_pkg::MODE_FUSED) begin
              if (pcount < ofp_pkg::MIN_LEN_FUSED_FLOW) begin
                res.result_kind = ofp_pkg::KIND_LEN_ERR;
              end else begin
                res.result_kind  = ofp_pkg::KIND_FUSED_FLOW;
                res.quality      = pl[1];
                res.dx_fused     = {pl[2], pl[3]};
                res.dy_fused     = {pl[4], pl[5]};
                res.dx_corrected = {pl[6], pl[7]};
                res.dy_corrected = {pl[8], pl[9]};
                res.light_level  = pl[14];
                seen_next[0]     = 1'b1;
              end
            end else begin
              res.result_kind = ofp_pkg::KIND_IGNORED;
            end
          end else if (func_b == ofp_pkg::FUNC_HEIGHT) begin
            if (mode_b > ofp_pkg::MODE_FUSED) begin
              res.result_kind = ofp_pkg::KIND_IGNORED;
            end else if (pcount < ofp_pkg::MIN_LEN_HEIGHT) begin
              res.result_kind = ofp_pkg::KIND_LEN_ERR;
            end else begin
              res.altitude = {pl[1], pl[2]};
              if (mode_b == ofp_pkg::MODE_RAW) begin
                res.result_kind = ofp_pkg::KIND_RAW_HEIGHT;
                seen_next[1]    = 1'b1;
              end else begin
                res.result_kind = ofp_pkg::KIND_FUSED_HEIGHT;
              end
            end
          end else begin
            res.result_kind = ofp_pkg::KIND_IGNORED;
          end
        end
        default: begin
          phase_next = PH_HUNT;
        end
      endcase
    end
    res.link_ok = link_next;
  end

  // Frame byte capture
  always_ff @(posedge clk) begin
    if (pop && store_func) begin
      func_b <= b;
    end
    if (pop && store_pl) begin
      if (pcount == '0) begin
        mode_b <= b;
      end
      for (int i = 1; i <= ofp_pkg::PL_KEEP; i++) begin
        if (pcount == ofp_pkg::LEN_W'(i)) begin
          pl[i] <= b;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_result <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HUNT;
      left       <= '0;
      pcount     <= '0;
      rsum       <= '0;
      seen       <= '0;
      sil0       <= ofp_pkg::SILENCE_CEILING_RESET;
      sil1       <= ofp_pkg::SILENCE_CEILING_RESET;
      link_state <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (pop) begin
        phase      <= phase_next;
        left       <= left_next;
        pcount     <= pcount_next;
        rsum       <= rsum_next;
        seen       <= seen_next;
        sil0       <= sil0_next;
        sil1       <= sil1_next;
        link_state <= link_next;
        out_valid  <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_tick_clears_seen: assert property (@(posedge clk) disable iff (rst)
    pop && q_item.is_tick |=> seen == 2'b00)
    else $error("seen flags not cleared by tick");

  a_byte_keeps_silence: assert property (@(posedge clk) disable iff (rst)
    pop && !q_item.is_tick |=> $stable(sil0) && $stable(sil1) && $stable(link_state))
    else $error("watchdog state changed on a byte");

  a_link_rise_on_tick: assert property (@(posedge clk) disable iff (rst)
    $rose(link_state) |-> $past(pop && q_item.is_tick))
    else $error("link came up without a tick");

  a_result_tracks_link: assert property (@(posedge clk) disable iff (rst)
    pop |=> out_valid && (out_result.link_ok == link_state))
    else $error("result link flag out of step with link state");
`endif

endmodule

### hw/rtl/optical_flow_frame_parser.sv
`timescale 1ns / 1ps

// Optical-flow sensor frame parser with link watchdog. Each input transfer is
// either a received serial byte or a millisecond tick (tuser), and each one
// yields exactly one result transfer, in order: busy while a frame builds up,
// a decoded flow or height record, a checksum / length / ignored status when
// a frame ends, or a health report on a tick. Frames are AA 22 dst func len
// payload sum, with an 8-bit additive checksum over every earlier byte. The
// block sustains one transfer per clock while the result stream takes its
// results: a four-entry queue holds classified items and a single output
// register holds the result, so the input keeps taking transfers while a
// result waits, until the queue is full. Each item goes from its queue entry,
// written when its input transfer is taken, through the combinational parser
// into the output register when the entry is popped. The parser keeps only
// the frame bytes it decodes, in registers, so there is no memory and no
// clearing after reset. Write the link timeout and silence ceiling only while
// the block is idle.
module optical_flow_frame_parser (
  input  logic          clk,
  input  logic          rst,

  // Input stream
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [15:0]   s_axis_tdata,   // [7:0] rx_byte, [15:8] tick_ms
  input  logic          s_axis_tuser,   // [0] req_type (1 = tick)

  // Result stream
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // [7:0] quality, [15:8] dx_raw, [23:16] dy_raw, [31:24] light_level,
  // [47:32] dx_fused, [63:48] dy_fused, [79:64] dx_corrected,
  // [95:80] dy_corrected, [111:96] altitude, [112] link_ok, [119:113] zero
  output logic [119:0]  m_axis_tdata,
  output logic [3:0]    m_axis_tuser,   // [3:0] result_kind

  // Configuration writes
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [15:0]   cfg_data
);

  ofp_pkg::cfg_t     cfg;
  ofp_pkg::item_t    q_item;
  ofp_pkg::result_t  result;
  logic              q_valid;
  logic              q_ready;

  // Configuration registers; hold their values between writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.link_timeout_ms    <= ofp_pkg::LINK_TIMEOUT_RESET;
      cfg.silence_ceiling_ms <= ofp_pkg::SILENCE_CEILING_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        ofp_pkg::REG_LINK_TIMEOUT:    cfg.link_timeout_ms    <= cfg_data;
        ofp_pkg::REG_SILENCE_CEILING: cfg.silence_ceiling_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front: accept and classify each transfer, queue it for the parser
  ofp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_type  (s_axis_tuser),
    .in_data  (s_axis_tdata),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item)
  );

  // Back: frame parser, decoder and silence watchdog with the result register
  ofp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_item     (q_item),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_result (result)
  );

  // Pack the result; fields without meaning for the kind are already zero
  assign m_axis_tuser = result.result_kind;
  assign m_axis_tdata = {7'b0,
                         result.link_ok,
                         result.altitude,
                         result.dy_corrected,
                         result.dx_corrected,
                         result.dy_fused,
                         result.dx_fused,
                         result.light_level,
                         result.dy_raw,
                         result.dx_raw,
                         result.quality};

endmodule
